/* design/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet helpers shared by the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

	localparam int MAX_RESULTS = 6;
	localparam int NUM_W       = 3;
	localparam int CFG_IDX_W   = 2;

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_EQ  = 8'h3D;

	localparam logic [7:0] LINE_LEN_RESET = 8'd72;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEN = 2'd1;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_error;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_item_t;

	// cnt_big marks a group count that ran past three (a stream that switched
	// from decode to encode with three symbols of a group held); cnt_lo holds the
	// two low bits of the count.
	typedef struct packed {
		logic [23:0] group_bits;
		logic [1:0]  cnt_lo;
		logic        cnt_big;
		logic [8:0]  line_count;
		logic        pad_seen;
	} codec_state_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] chars;
		logic [NUM_W-1:0]            num;
		logic                        error;
	} result_set_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sym_t;

	function automatic logic [7:0] enc_sym(input logic [5:0] s);
		logic [7:0] c;
		c = {2'b00, s};
		if (s < 6'd26)
			return c + 8'd65;
		else if (s < 6'd52)
			return c + 8'd71;
		else if (s < 6'd62)
			return c - 8'd4;
		else if (s == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

	function automatic sym_t dec_sym(input logic [7:0] c);
		sym_t r;
		r = '0;
		if (c inside {[8'h41:8'h5A]}) begin
			r.ok  = 1'b1;
			r.val = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			r.ok  = 1'b1;
			r.val = 6'(c - 8'd71);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.ok  = 1'b1;
			r.val = 6'(c + 8'd4);
		end else if (c == 8'h2B) begin
			r.ok  = 1'b1;
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.ok  = 1'b1;
			r.val = 6'd63;
		end
		return r;
	endfunction

endpackage

/* design/b64c_stream_if.sv */
// ----------------------------------------------------------------------------
// b64c_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface b64c_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/base64_codec_stream.sv */
// ----------------------------------------------------------------------------
// base64_codec_stream
// Streaming Base64 encoder and decoder with line wrapping and padding.
// ----------------------------------------------------------------------------
//  channel  direction  payload                          transaction
//  items    in         in_byte[7:0], in_end             one byte or end mark
//  results  out        out_char[7:0], out_error, out_last  one character/byte
//  cfg      in         index[1:0], data[7:0]            one register write
//
// An accepted item is registered in the input register, then its result set
// is built in one pass and loaded into the result buffer once it is free, and
// the buffer presents its first result. Items that give no result do not wait
// for the buffer; an item with n results holds the output until all n are
// taken from the single result buffer, which drains one result per cycle while
// the output is ready (four characters per three bytes when encoding, five
// when a newline follows). Stalls on either side only hold the registers.
// Reset restores mode encode, line length 72 and a cleared group.
// ----------------------------------------------------------------------------
module base64_codec_stream (
	input logic           clk,
	input logic           arst_n,
	b64c_stream_if.sink   items,
	b64c_stream_if.source results,
	b64c_stream_if.sink   cfg
);

	b64c_pkg::in_item_t     item_s1;
	logic                   valid_s1;
	b64c_pkg::codec_state_t state_q;
	b64c_pkg::codec_state_t state_nxt;
	b64c_pkg::result_set_t  res;
	logic                   mode_q;
	logic [7:0]             line_len_q;
	logic                   buf_free;
	logic                   commit;
	logic                   load;

	assign commit      = valid_s1 && ((res.num == '0) || buf_free);
	assign load        = commit && (res.num != '0);
	assign items.ready = !valid_s1 || commit;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid)
			item_s1 <= items.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (commit) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= b64c_pkg::MODE_ENCODE;
			line_len_q <= b64c_pkg::LINE_LEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				b64c_pkg::CFG_MODE:     mode_q     <= cfg.data.data[0];
				b64c_pkg::CFG_LINE_LEN: line_len_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	b64c_engine u_engine (
		.item        (item_s1),
		.st          (state_q),
		.mode        (mode_q),
		.line_length (line_len_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	b64c_result_buf u_result_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.res     (res),
		.free    (buf_free),
		.results (results)
	);

	// The end of a stream leaves no group, line or pad state behind.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item_s1.in_end |=> state_q == '0)
		else $error("state not cleared after end of stream");

	// An error is always a lone result carrying a zero character.
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.out_error |->
			results.data.out_last && (results.data.out_char == 8'h00))
		else $error("error result is not a single zero result");

	// An item waiting in the input register is neither lost nor altered.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !commit |=> valid_s1 && $stable(item_s1))
		else $error("input register changed while waiting");

endmodule

/* design/b64c_engine.sv */
// ----------------------------------------------------------------------------
// b64c_engine
// Combinational step: one item and the current state give the result set and
// the next state.
// ----------------------------------------------------------------------------
module b64c_engine (
	input  b64c_pkg::in_item_t     item,
	input  b64c_pkg::codec_state_t st,
	input  logic                   mode,
	input  logic [7:0]             line_length,
	output b64c_pkg::codec_state_t nxt,
	output b64c_pkg::result_set_t  res
);

	logic [23:0]        gb_enc;
	logic [23:0]        gb_dec;
	logic [23:0]        q_bits;
	logic               q_all_real;
	logic [3:0][7:0]    quad;
	logic [2:0][7:0]    bytes_eq;
	logic [2:0][7:0]    bytes_full;
	logic [8:0]         lc4;
	logic               nl;
	b64c_pkg::sym_t     sym;
	logic               has_group;

	always_comb begin
		// New bits are merged into what the group already holds, which matters
		// when a mode change leaves bits of the other format behind.
		gb_enc = st.group_bits;
		case (st.cnt_lo)
			2'd0: gb_enc[23:16] = gb_enc[23:16] | item.in_byte;
			2'd1: gb_enc[15:8]  = gb_enc[15:8] | item.in_byte;
			2'd2: gb_enc[7:0]   = gb_enc[7:0] | item.in_byte;
			default: ;
		endcase

		sym    = b64c_pkg::dec_sym(item.in_byte);
		gb_dec = st.group_bits;
		case (st.cnt_lo)
			2'd0: gb_dec[23:18] = gb_dec[23:18] | sym.val;
			2'd1: gb_dec[17:12] = gb_dec[17:12] | sym.val;
			2'd2: gb_dec[11:6]  = gb_dec[11:6] | sym.val;
			default: gb_dec[5:0] = gb_dec[5:0] | sym.val;
		endcase

		lc4       = st.line_count + 9'd4;
		nl        = lc4 >= {1'b0, line_length};
		has_group = st.cnt_big || (st.cnt_lo != 2'd0);

		// A group closed mid-stream always holds three real bytes.
		q_bits     = item.in_end ? st.group_bits : gb_enc;
		q_all_real = item.in_end ? st.cnt_big : 1'b1;
		for (int k = 0; k < 4; k++) begin
			if (!q_all_real && (2'(k) > st.cnt_lo))
				quad[k] = b64c_pkg::CHAR_PAD;
			else
				quad[k] = b64c_pkg::enc_sym(q_bits[23-6*k -: 6]);
		end
		for (int k = 0; k < 3; k++) begin
			bytes_eq[k]   = st.group_bits[23-8*k -: 8];
			bytes_full[k] = gb_dec[23-8*k -: 8];
		end
	end

	always_comb begin
		nxt = st;
		res = '0;
		if (mode == b64c_pkg::MODE_ENCODE) begin
			if (item.in_end) begin
				if (has_group) begin
					for (int k = 0; k < 4; k++)
						res.chars[k] = quad[k];
					res.chars[4] = b64c_pkg::CHAR_NL;
					res.chars[5] = b64c_pkg::CHAR_NL;
					res.num      = nl ? 3'd6 : 3'd5;
				end else begin
					res.chars[0] = b64c_pkg::CHAR_NL;
					res.num      = 3'd1;
				end
				nxt = '0;
			end else begin
				nxt.group_bits = gb_enc;
				if (st.cnt_big) begin
					nxt.cnt_lo = st.cnt_lo + 2'd1;
				end else if (st.cnt_lo == 2'd3) begin
					nxt.cnt_lo  = 2'd0;
					nxt.cnt_big = 1'b1;
				end else if (st.cnt_lo == 2'd2) begin
					for (int k = 0; k < 4; k++)
						res.chars[k] = quad[k];
					res.chars[4]   = b64c_pkg::CHAR_NL;
					res.num        = nl ? 3'd5 : 3'd4;
					nxt.group_bits = '0;
					nxt.cnt_lo     = 2'd0;
					nxt.line_count = nl ? 9'd0 : lc4;
				end else begin
					nxt.cnt_lo = st.cnt_lo + 2'd1;
				end
			end
		end else begin
			if (item.in_end) begin
				if (!st.pad_seen && has_group) begin
					res.num   = 3'd1;
					res.error = 1'b1;
				end
				nxt = '0;
			end else if (!st.pad_seen) begin
				if (item.in_byte == b64c_pkg::CHAR_EQ) begin
					for (int k = 0; k < 3; k++)
						res.chars[k] = bytes_eq[k];
					if (st.cnt_big)
						res.num = 3'd3;
					else if (st.cnt_lo != 2'd0)
						res.num = {1'b0, st.cnt_lo - 2'd1};
					nxt.pad_seen   = 1'b1;
					nxt.group_bits = '0;
					nxt.cnt_lo     = 2'd0;
					nxt.cnt_big    = 1'b0;
				end else if (sym.ok) begin
					nxt.group_bits = gb_dec;
					nxt.cnt_lo     = st.cnt_lo + 2'd1;
					nxt.cnt_big    = 1'b0;
					if (st.cnt_lo == 2'd3) begin
						for (int k = 0; k < 3; k++)
							res.chars[k] = bytes_full[k];
						res.num        = 3'd3;
						nxt.group_bits = '0;
					end
				end
			end
		end
	end

endmodule

/* design/b64c_result_buf.sv */
// ----------------------------------------------------------------------------
// b64c_result_buf
// Holds the result set of one item and hands it out one result per cycle while the output is ready.
// ----------------------------------------------------------------------------
module b64c_result_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  b64c_pkg::result_set_t res,
	output logic                  free,
	b64c_stream_if.source         results
);

	logic [b64c_pkg::MAX_RESULTS-1:0][7:0] chars_q;
	logic [b64c_pkg::NUM_W-1:0]            num_q;
	logic [b64c_pkg::NUM_W-1:0]            idx_q;
	logic                                  err_q;
	logic                                  take;
	logic                                  last;

	assign last = idx_q == (num_q - 3'd1);
	assign take = results.valid && results.ready;
	assign free = (num_q == '0) || (take && last);

	assign results.valid          = num_q != '0;
	assign results.data.out_char  = chars_q[idx_q];
	assign results.data.out_error = err_q;
	assign results.data.out_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			num_q <= res.num;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				num_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= res.chars;
			err_q   <= res.error;
		end
	end

endmodule
